@@ hdl/wem16_pkg.sv @@
// Package: WEM-16 cipher types, constants and GF(2^8) helper functions.
package wem16_pkg;

  localparam int CIPHER_ROUNDS = 12;
  localparam int AES_ROUNDS    = 5;
  localparam int RK_ENTRIES    = 2 * (AES_ROUNDS + 1);
  localparam int KEY_WORDS     = 4 * (AES_ROUNDS + 1);
  localparam int RK_W          = $clog2(RK_ENTRIES);
  localparam int KW_W          = $clog2(KEY_WORDS + 1);
  localparam int CR_W          = $clog2(CIPHER_ROUNDS + 1);
  localparam int AR_W          = $clog2(AES_ROUNDS + 1);
  localparam int TAB_DEPTH     = 65536;

  typedef enum logic [1:0] {
    OP_LOAD_FWD = 2'd0,
    OP_LOAD_INV = 2'd1,
    OP_ENCRYPT  = 2'd2,
    OP_DECRYPT  = 2'd3
  } op_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB_ADDR,
    ST_TAB_WAIT,
    ST_TAB_TAKE,
    ST_AES,
    ST_DONE
  } state_t;

  typedef logic [15:0] word_t;
  typedef logic [127:0] block_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    gm = r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] sq;
    // x^254 via square-and-multiply on constant exponent
    inv = 8'h01;
    sq = x;
    for (int k = 1; k < 8; k++) begin
      sq = gm(sq, sq);
      inv = gm(inv, sq);
    end
    sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] s);
    logic [7:0] r;
    r = '0;
    for (int x = 0; x < 256; x++) begin
      if (sbox(8'(x)) == s) r = 8'(x);
    end
    sbox_inv = r;
  endfunction

  function automatic logic [255:0][7:0] build_s();
    logic [255:0][7:0] t;
    for (int x = 0; x < 256; x++) t[x] = sbox(8'(x));
    build_s = t;
  endfunction

  function automatic logic [255:0][7:0] build_si();
    logic [255:0][7:0] t;
    for (int x = 0; x < 256; x++) t[sbox(8'(x))] = 8'(x);
    build_si = t;
  endfunction

  localparam logic [255:0][7:0] S_TAB  = build_s();
  localparam logic [255:0][7:0] SI_TAB = build_si();

  localparam int SR_FWD [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
  localparam int SR_INV [16] = '{0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3};

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    sub_word = {S_TAB[a[31:24]], S_TAB[a[23:16]], S_TAB[a[15:8]], S_TAB[a[7:0]]};
  endfunction

endpackage

@@ hdl/wem16_if.sv @@
// Valid/ready stream interfaces for request and result channels.
interface wem16_req_if (input logic clk);
  logic valid;
  logic ready;
  wem16_pkg::op_t operation;
  logic [15:0] table_index;
  logic [15:0] table_value;
  logic [15:0] in_word0;
  logic [15:0] in_word1;
  logic [15:0] in_word2;
  logic [15:0] in_word3;
  logic [15:0] in_word4;
  logic [15:0] in_word5;
  logic [15:0] in_word6;
  logic [15:0] in_word7;
  modport source (output valid, operation, table_index, table_value, in_word0, in_word1,
                  in_word2, in_word3, in_word4, in_word5, in_word6, in_word7, input ready);
  modport sink (input valid, operation, table_index, table_value, in_word0, in_word1,
                in_word2, in_word3, in_word4, in_word5, in_word6, in_word7, output ready);
endinterface

interface wem16_res_if (input logic clk);
  logic valid;
  logic ready;
  logic [15:0] out_word0;
  logic [15:0] out_word1;
  logic [15:0] out_word2;
  logic [15:0] out_word3;
  logic [15:0] out_word4;
  logic [15:0] out_word5;
  logic [15:0] out_word6;
  logic [15:0] out_word7;
  modport source (output valid, out_word0, out_word1, out_word2, out_word3, out_word4,
                  out_word5, out_word6, out_word7, input ready);
  modport sink (input valid, out_word0, out_word1, out_word2, out_word3, out_word4,
                out_word5, out_word6, out_word7, output ready);
endinterface

@@ hdl/wem16_ram.sv @@
// Generic single-port RAM with registered read.
module wem16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hdl/wem16_keyexp.sv @@
// Round key expansion: one key word per cycle into the round key store.
module wem16_keyexp (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [wem16_pkg::RK_W-1:0] rk_sel,
  output logic [127:0] rk_out,
  output logic        busy
);
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [31:0] w [wem16_pkg::KEY_WORDS];
  logic [wem16_pkg::KW_W-1:0] cnt;
  logic [7:0] rc;
  logic [31:0] t;
  logic [31:0] prev;
  logic [31:0] back4;
  logic [wem16_pkg::KW_W-1:0] cnt_m1;
  logic [wem16_pkg::KW_W-1:0] cnt_m4;

  assign cnt_m1 = cnt - wem16_pkg::KW_W'(1);
  assign cnt_m4 = cnt - wem16_pkg::KW_W'(4);
  assign prev = w[cnt_m1[$clog2(wem16_pkg::KEY_WORDS)-1:0]];
  assign back4 = w[cnt_m4[$clog2(wem16_pkg::KEY_WORDS)-1:0]];
  assign busy = (cnt != wem16_pkg::KW_W'(wem16_pkg::KEY_WORDS));

  always_comb begin
    t = prev;
    if (cnt[1:0] == 2'd0) t = wem16_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc, 24'h0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      cnt <= wem16_pkg::KW_W'(4);
      rc <= 8'h01;
      w[0] <= '0;
      w[1] <= '0;
      w[2] <= '0;
      w[3] <= '0;
    end else if (cfg_we && (cfg_index == wem16_pkg::REG_KEY_HIGH)) begin
      key_high <= cfg_data;
      w[0] <= cfg_data[63:32];
      w[1] <= cfg_data[31:0];
      w[2] <= key_low[63:32];
      w[3] <= key_low[31:0];
      cnt <= wem16_pkg::KW_W'(4);
      rc <= 8'h01;
    end else if (cfg_we) begin
      key_low <= cfg_data;
      w[0] <= key_high[63:32];
      w[1] <= key_high[31:0];
      w[2] <= cfg_data[63:32];
      w[3] <= cfg_data[31:0];
      cnt <= wem16_pkg::KW_W'(4);
      rc <= 8'h01;
    end else if (busy) begin
      w[cnt[$clog2(wem16_pkg::KEY_WORDS)-1:0]] <= back4 ^ t;
      if (cnt[1:0] == 2'd0) rc <= wem16_pkg::xt(rc);
      cnt <= cnt + wem16_pkg::KW_W'(1);
    end
  end

  logic [$clog2(wem16_pkg::KEY_WORDS)-1:0] base;
  assign base = {rk_sel, 1'b0} << 1;
  assign rk_out = {w[base], w[base + 1'b1], w[base + 2'd2], w[base + 2'd3]};
endmodule

@@ hdl/whitebox_wem16_block_cipher_unit.sv @@
// Top level: WEM-16 white-box block cipher with shared AES round datapath.
// Load: a table write is taken while idle and the unit stays idle. Block: each of the 13
//   table layers reads its 8 words through TAB_ADDR, TAB_WAIT and TAB_TAKE, and each of
//   the 12 AES layers steps its AES round from 0 to AES_ROUNDS.
// Ready is low while a block is pending and during key expansion after a key write.
// Reset (synchronous, rst high) clears control and expands the zero key; tables undefined.
module whitebox_wem16_block_cipher_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  wem16_req_if.sink       req,
  wem16_res_if.source     res
);
  wem16_pkg::state_t state, state_next;
  logic        dec;
  logic [127:0] blk;
  logic [2:0]  widx;
  logic [wem16_pkg::CR_W-1:0] cround;
  logic [wem16_pkg::AR_W-1:0] around;
  logic        kbusy;
  logic [127:0] rk;
  logic [wem16_pkg::RK_W-1:0] rk_sel;
  logic [15:0] fwd_rd, inv_rd;
  logic [15:0] tab_addr;
  logic        fwd_we, inv_we;

  wem16_keyexp u_keyexp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
    .rk_sel(rk_sel), .rk_out(rk), .busy(kbusy)
  );

  assign tab_addr = (state == wem16_pkg::ST_IDLE) ? req.table_index : blk[127 - 16*widx -: 16];
  assign fwd_we = req.valid && req.ready && (req.operation == wem16_pkg::OP_LOAD_FWD);
  assign inv_we = req.valid && req.ready && (req.operation == wem16_pkg::OP_LOAD_INV);

  wem16_ram #(.WIDTH(16), .DEPTH(wem16_pkg::TAB_DEPTH)) u_fwd (
    .clk(clk), .we(fwd_we), .addr(tab_addr), .wdata(req.table_value), .rdata(fwd_rd)
  );
  wem16_ram #(.WIDTH(16), .DEPTH(wem16_pkg::TAB_DEPTH)) u_inv (
    .clk(clk), .we(inv_we), .addr(tab_addr), .wdata(req.table_value), .rdata(inv_rd)
  );

  assign req.ready = (state == wem16_pkg::ST_IDLE) && !kbusy;

  // AES round key index for the current step
  assign rk_sel = dec ? wem16_pkg::RK_W'(wem16_pkg::AES_ROUNDS - around)
                      : wem16_pkg::RK_W'(around);

  // shared AES round unit
  logic [127:0] aes_out;
  always_comb begin
    logic [7:0] b [16];
    logic [7:0] p [16];
    logic [7:0] a0, a1, a2, a3, tt, t9, e, o;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; tt = '0; t9 = '0; e = '0; o = '0;
    for (int i = 0; i < 16; i++) b[i] = blk[127 - 8*i -: 8];
    if (!dec) begin
      if (around != '0) begin
        for (int i = 0; i < 16; i++) p[i] = wem16_pkg::S_TAB[b[wem16_pkg::SR_FWD[i]]];
        if (around != wem16_pkg::AR_W'(wem16_pkg::AES_ROUNDS)) begin
          for (int c = 0; c < 4; c++) begin
            a0 = p[4*c]; a1 = p[4*c+1]; a2 = p[4*c+2]; a3 = p[4*c+3];
            tt = a0 ^ a1 ^ a2 ^ a3;
            p[4*c]   = tt ^ a0 ^ wem16_pkg::xt(a0 ^ a1);
            p[4*c+1] = tt ^ a1 ^ wem16_pkg::xt(a1 ^ a2);
            p[4*c+2] = tt ^ a2 ^ wem16_pkg::xt(a2 ^ a3);
            p[4*c+3] = tt ^ a3 ^ wem16_pkg::xt(a3 ^ a0);
          end
        end
      end else begin
        for (int i = 0; i < 16; i++) p[i] = b[i];
      end
      for (int i = 0; i < 16; i++) p[i] = p[i] ^ rk[127 - 8*i -: 8];
    end else begin
      if (around != '0) begin
        for (int i = 0; i < 16; i++) p[i] = wem16_pkg::SI_TAB[b[wem16_pkg::SR_INV[i]]];
      end else begin
        for (int i = 0; i < 16; i++) p[i] = b[i];
      end
      for (int i = 0; i < 16; i++) p[i] = p[i] ^ rk[127 - 8*i -: 8];
      if (around != '0 && around != wem16_pkg::AR_W'(wem16_pkg::AES_ROUNDS)) begin
        for (int c = 0; c < 4; c++) begin
          a0 = p[4*c]; a1 = p[4*c+1]; a2 = p[4*c+2]; a3 = p[4*c+3];
          t9 = wem16_pkg::gm(8'h09, a0 ^ a1 ^ a2 ^ a3);
          e = wem16_pkg::gm(8'h04, a0 ^ a2);
          o = wem16_pkg::gm(8'h04, a1 ^ a3);
          p[4*c]   = a0 ^ t9 ^ e ^ wem16_pkg::gm(8'h02, a0 ^ a1);
          p[4*c+1] = a1 ^ t9 ^ o ^ wem16_pkg::gm(8'h02, a1 ^ a2);
          p[4*c+2] = a2 ^ t9 ^ e ^ wem16_pkg::gm(8'h02, a2 ^ a3);
          p[4*c+3] = a3 ^ t9 ^ o ^ wem16_pkg::gm(8'h02, a3 ^ a0);
        end
      end
    end
    for (int i = 0; i < 16; i++) aes_out[127 - 8*i -: 8] = p[i];
  end

  logic last_layer;
  // the table layer at round CIPHER_ROUNDS ends the block, in encrypt and decrypt alike
  assign last_layer = (cround == wem16_pkg::CR_W'(wem16_pkg::CIPHER_ROUNDS));

  always_comb begin
    state_next = state;
    case (state)
      wem16_pkg::ST_IDLE: begin
        if (req.valid && req.ready &&
            (req.operation == wem16_pkg::OP_ENCRYPT || req.operation == wem16_pkg::OP_DECRYPT))
          state_next = wem16_pkg::ST_TAB_ADDR;
      end
      wem16_pkg::ST_TAB_ADDR: state_next = wem16_pkg::ST_TAB_WAIT;
      wem16_pkg::ST_TAB_WAIT: state_next = wem16_pkg::ST_TAB_TAKE;
      wem16_pkg::ST_TAB_TAKE: begin
        if (widx != 3'd7) state_next = wem16_pkg::ST_TAB_ADDR;
        else if (last_layer) state_next = wem16_pkg::ST_DONE;
        else state_next = wem16_pkg::ST_AES;
      end
      wem16_pkg::ST_AES: begin
        if (around == wem16_pkg::AR_W'(wem16_pkg::AES_ROUNDS))
          state_next = wem16_pkg::ST_TAB_ADDR;
      end
      wem16_pkg::ST_DONE: if (res.ready) state_next = wem16_pkg::ST_IDLE;
      default: state_next = wem16_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wem16_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
      cround <= '0;
      around <= '0;
      dec <= 1'b0;
    end else begin
      case (state)
        wem16_pkg::ST_IDLE: begin
          blk <= {req.in_word0, req.in_word1, req.in_word2, req.in_word3,
                  req.in_word4, req.in_word5, req.in_word6, req.in_word7};
          dec <= (req.operation == wem16_pkg::OP_DECRYPT);
          widx <= '0;
          cround <= '0;
          around <= '0;
        end
        wem16_pkg::ST_TAB_TAKE: begin
          blk[127 - 16*widx -: 16] <= dec ? inv_rd : fwd_rd;
          widx <= widx + 3'd1;
          around <= '0;
          if (widx == 3'd7 && dec && cround == '0) begin
            cround <= cround;
          end
        end
        wem16_pkg::ST_AES: begin
          blk <= aes_out;
          around <= around + wem16_pkg::AR_W'(1);
          if (around == wem16_pkg::AR_W'(wem16_pkg::AES_ROUNDS))
            cround <= cround + wem16_pkg::CR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign res.valid = (state == wem16_pkg::ST_DONE);
  assign res.out_word0 = blk[127:112];
  assign res.out_word1 = blk[111:96];
  assign res.out_word2 = blk[95:80];
  assign res.out_word3 = blk[79:64];
  assign res.out_word4 = blk[63:48];
  assign res.out_word5 = blk[47:32];
  assign res.out_word6 = blk[31:16];
  assign res.out_word7 = blk[15:0];

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == wem16_pkg::ST_IDLE))
    else $error("ready outside idle");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(blk)))
    else $error("result changed while stalled");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    cround <= wem16_pkg::CR_W'(wem16_pkg::CIPHER_ROUNDS))
    else $error("cipher round overrun");
  a_no_key_busy: assert property (@(posedge clk) disable iff (rst)
    (state == wem16_pkg::ST_IDLE && $past(state) == wem16_pkg::ST_DONE) |-> !res.valid)
    else $error("result repeated");
endmodule
